>>> hdl/pata_pkg.sv
// ----------------------------------------------------------------------------
// pata_pkg
// Shared types, request codes and helpers for the planar affine transform
// accumulator.
// ----------------------------------------------------------------------------
package pata_pkg;

    typedef enum logic [2:0] {
        REQ_ROT_CW  = 3'd0,
        REQ_ROT_CCW = 3'd1,
        REQ_REFL_X  = 3'd2,
        REQ_REFL_Y  = 3'd3,
        REQ_POINT   = 3'd4
    } req_t;

    // linear coefficient, always -1, 0 or +1
    typedef logic signed [1:0] coef_t;

    typedef struct packed {
        coef_t       r0x;
        coef_t       r0y;
        coef_t       r1x;
        coef_t       r1y;
        logic [63:0] sx;
        logic [63:0] sy;
    } xform_t;

    // update command from the input stage to the transform register
    typedef struct packed {
        logic        en;
        req_t        kind;
        logic [31:0] line_pos;
    } upd_t;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        sext32 = {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] scale(input coef_t c, input logic [63:0] v);
        case (c)
            2'sd1:   scale = v;
            -2'sd1:  scale = 64'd0 - v;
            default: scale = 64'd0;
        endcase
    endfunction

endpackage

>>> hdl/planar_affine_transform_accumulator_top.sv
// ----------------------------------------------------------------------------
// planar_affine_transform_accumulator_top
// Accumulated 2D affine transform with rotate, mirror and point requests.
// ----------------------------------------------------------------------------
// One request is taken per cycle while no stalled result holds a point
// request. A request is held in the input register, then updates the
// transform or, for a point request, loads the result register, which
// presents the result on the output. Only point requests give a result; a
// stalled result holds a point request, and everything behind it, in the
// input register, while rotate and mirror requests ahead of it still pass.
// Codes 5 to 7 are accepted and dropped.
module planar_affine_transform_accumulator_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // line_pos, point_x, point_y
    input  logic [2:0]    s_tuser,   // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // out_x, out_y
);
    import pata_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    req_t        in_kind_reg;
    logic [31:0] in_line_reg;
    logic [31:0] in_px_reg;
    logic [31:0] in_py_reg;
    logic        advance;
    logic        load;
    upd_t        upd;
    xform_t      xform;
    logic [63:0] out_x;
    logic [63:0] out_y;

    assign advance  = in_valid_reg & ((in_kind_reg != REQ_POINT) | ~m_tvalid | m_tready);
    assign load     = advance & (in_kind_reg == REQ_POINT);
    assign s_tready = ~in_valid_reg | advance;
    assign in_valid_next = (s_tvalid & s_tready) | (in_valid_reg & ~advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= req_t'(s_tuser);
            in_line_reg <= s_tdata[31:0];
            in_px_reg   <= s_tdata[63:32];
            in_py_reg   <= s_tdata[95:64];
        end
    end

    assign upd.en       = advance;
    assign upd.kind     = in_kind_reg;
    assign upd.line_pos = in_line_reg;

    pata_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .xform   (xform)
    );

    pata_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .xform    (xform),
        .point_x  (in_px_reg),
        .point_y  (in_py_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_x    (out_x),
        .out_y    (out_y)
    );

    assign m_tdata = {out_y, out_x};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");
    a_point_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_kind_reg == REQ_POINT && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while point request is stalled");
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted request lost");
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input register not ready");

endmodule

>>> hdl/pata_state.sv
// ----------------------------------------------------------------------------
// pata_state
// Accumulated transform register: applies quarter turns and mirrors to the
// linear part and the 64-bit translation.
// ----------------------------------------------------------------------------
module pata_state (
    input  logic            aclk,
    input  logic            aresetn,
    input  pata_pkg::upd_t  upd,
    output pata_pkg::xform_t xform
);
    import pata_pkg::*;

    xform_t      xf_reg;
    xform_t      xf_next;
    logic [63:0] twice_p;

    assign twice_p = {{31{upd.line_pos[31]}}, upd.line_pos, 1'b0};

    always_comb begin
        xf_next = xf_reg;
        if (upd.en) begin
            case (upd.kind)
                REQ_ROT_CW: begin
                    xf_next.r0x = xf_reg.r1x;
                    xf_next.r0y = xf_reg.r1y;
                    xf_next.sx  = xf_reg.sy;
                    xf_next.r1x = -xf_reg.r0x;
                    xf_next.r1y = -xf_reg.r0y;
                    xf_next.sy  = 64'd0 - xf_reg.sx;
                end
                REQ_ROT_CCW: begin
                    xf_next.r0x = -xf_reg.r1x;
                    xf_next.r0y = -xf_reg.r1y;
                    xf_next.sx  = 64'd0 - xf_reg.sy;
                    xf_next.r1x = xf_reg.r0x;
                    xf_next.r1y = xf_reg.r0y;
                    xf_next.sy  = xf_reg.sx;
                end
                REQ_REFL_X: begin
                    xf_next.r0x = -xf_reg.r0x;
                    xf_next.r0y = -xf_reg.r0y;
                    xf_next.sx  = twice_p - xf_reg.sx;
                end
                REQ_REFL_Y: begin
                    xf_next.r1x = -xf_reg.r1x;
                    xf_next.r1y = -xf_reg.r1y;
                    xf_next.sy  = twice_p - xf_reg.sy;
                end
                default: begin
                    xf_next = xf_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xf_reg.r0x <= 2'sd1;
            xf_reg.r0y <= 2'sd0;
            xf_reg.r1x <= 2'sd0;
            xf_reg.r1y <= 2'sd1;
            xf_reg.sx  <= 64'd0;
            xf_reg.sy  <= 64'd0;
        end else begin
            xf_reg <= xf_next;
        end
    end

    assign xform = xf_reg;

    // linear part stays a signed permutation matrix
    a_row0_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (xf_reg.r0x != 2'sd0) ^ (xf_reg.r0y != 2'sd0))
        else $error("row 0 of linear part lost its single nonzero entry");
    a_row1_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (xf_reg.r1x != 2'sd0) ^ (xf_reg.r1y != 2'sd0))
        else $error("row 1 of linear part lost its single nonzero entry");
    a_col_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (xf_reg.r0x != 2'sd0) ^ (xf_reg.r1x != 2'sd0))
        else $error("linear part is singular");
    a_point_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd.en && upd.kind == REQ_POINT) |=> $stable(xf_reg))
        else $error("point request altered the transform");

endmodule

>>> hdl/pata_eval.sv
// ----------------------------------------------------------------------------
// pata_eval
// Maps a query point through the current transform into the result register.
// ----------------------------------------------------------------------------
module pata_eval (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  pata_pkg::xform_t xform,
    input  logic [31:0]      point_x,
    input  logic [31:0]      point_y,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [63:0]      out_x,
    output logic [63:0]      out_y
);
    import pata_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] x_next;
    logic [63:0] y_next;
    logic [63:0] px;
    logic [63:0] py;

    assign px = sext32(point_x);
    assign py = sext32(point_y);

    always_comb begin
        x_next     = scale(xform.r0x, px) + scale(xform.r0y, py) + xform.sx;
        y_next     = scale(xform.r1x, px) + scale(xform.r1y, py) + xform.sy;
        valid_next = load | (valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the planar affine transform accumulator. Rotate, mirror, point and
// spare-code requests are streamed in, first from a short directed table and
// then at random. A local copy of the transform predicts each point result
// that the table does not give, and the results are compared in order as they
// leave the block. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb;
    import pata_pkg::*;

    localparam logic [2:0] CODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] CODE_SPARE_MID = 3'd6;
    localparam logic [2:0] CODE_SPARE_HI  = 3'd7;
    localparam int RANDOM_REQS = 800;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
    } point_t;

    typedef struct {
        logic [2:0]  code;
        logic [31:0] p;
        logic [31:0] x;
        logic [31:0] y;
        bit          typed;
        logic [63:0] ex;
        logic [63:0] ey;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;
    logic [2:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;

    coef_t         c00, c01, c10, c11;
    logic [63:0]   off_x, off_y;
    point_t        pending_points[$];
    row_t          directed[$];
    int            errors = 0;
    int            quiet_cycles = 0;
    bit            calm = 1'b0;

    planar_affine_transform_accumulator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // updates the held transform; flags a point result and its value
    task automatic advance_transform(input logic [2:0] code, input logic [31:0] p,
                                     input logic [31:0] x, input logic [31:0] y,
                                     output bit has_pt, output point_t pt);
        coef_t              a, b;
        logic [63:0]        t;
        logic signed [63:0] pw, xs, ys;
        pw = $signed(p);
        xs = $signed(x);
        ys = $signed(y);
        has_pt = 1'b0;
        pt = '{64'd0, 64'd0};
        case (req_t'(code))
            REQ_ROT_CW: begin
                a = c00; b = c01; t = off_x;
                c00 = c10; c01 = c11; off_x = off_y;
                c10 = -a; c11 = -b; off_y = 64'd0 - t;
            end
            REQ_ROT_CCW: begin
                a = c00; b = c01; t = off_x;
                c00 = -c10; c01 = -c11; off_x = 64'd0 - off_y;
                c10 = a; c11 = b; off_y = t;
            end
            REQ_REFL_X: begin
                c00 = -c00; c01 = -c01;
                off_x = (pw + pw) - off_x;
            end
            REQ_REFL_Y: begin
                c10 = -c10; c11 = -c11;
                off_y = (pw + pw) - off_y;
            end
            REQ_POINT: begin
                has_pt = 1'b1;
                pt.x = 64'(c00 * xs) + 64'(c01 * ys) + off_x;
                pt.y = 64'(c10 * xs) + 64'(c11 * ys) + off_y;
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input row_t r);
        bit     has_pt;
        point_t pt;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.code;
        s_tdata  <= {r.y, r.x, r.p};
        do @(posedge aclk); while (!s_tready);
        advance_transform(r.code, r.p, r.x, r.y, has_pt, pt);
        if (has_pt) begin
            if (r.typed) begin
                pt.x = r.ex;
                pt.y = r.ey;
            end
            pending_points.push_back(pt);
        end
    endtask

    task automatic add_row(input logic [2:0] code, input logic [31:0] p,
                           input logic [31:0] x, input logic [31:0] y,
                           input bit typed = 1'b0,
                           input logic [63:0] ex = 64'd0, input logic [63:0] ey = 64'd0);
        row_t r;
        r = '{code, p, x, y, typed, ex, ey};
        directed.push_back(r);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: pick_word = 32'h8000_0000;
            1: pick_word = 32'h7fff_ffff;
            2: pick_word = 32'h0000_0000;
            3: pick_word = 32'hffff_ffff;
            4: pick_word = 32'($signed($urandom_range(200)) - 100);
            default: pick_word = $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 14)      pick_code = REQ_ROT_CW;
        else if (r < 28) pick_code = REQ_ROT_CCW;
        else if (r < 44) pick_code = REQ_REFL_X;
        else if (r < 60) pick_code = REQ_REFL_Y;
        else if (r < 95) pick_code = REQ_POINT;
        else             pick_code = 3'($urandom_range(CODE_SPARE_HI, CODE_SPARE_LO));
    endfunction

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        point_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h", $time,
                         m_tdata[63:0], m_tdata[127:64]);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[63:0] !== want.x) begin
                    $display("%0t: out_x expected %h actual %h", $time,
                             want.x, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== want.y) begin
                    $display("%0t: out_y expected %h actual %h", $time,
                             want.y, m_tdata[127:64]);
                    errors++;
                end
            end
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        row_t r;
        c00 = 2'sd1; c01 = 2'sd0; c10 = 2'sd0; c11 = 2'sd1;
        off_x = 64'd0; off_y = 64'd0;

        add_row(REQ_POINT, 32'h1234_5678, 32'd0, 32'd0, 1, 64'd0, 64'd0);
        add_row(REQ_POINT, $urandom, 32'h7fff_ffff, 32'h8000_0000, 1,
                64'h0000_0000_7fff_ffff, 64'hffff_ffff_8000_0000);
        add_row(CODE_SPARE_LO, $urandom, $urandom, $urandom);
        add_row(CODE_SPARE_MID, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        add_row(CODE_SPARE_HI, $urandom, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'd3, -32'sd7, 1, 64'd3, -64'sd7);
        add_row(REQ_ROT_CW, $urandom, $urandom, $urandom);
        add_row(REQ_POINT, 32'd0, 32'd1, 32'd2, 1, 64'd2, -64'sd1);
        add_row(REQ_ROT_CCW, $urandom, $urandom, $urandom);
        add_row(REQ_POINT, 32'd0, 32'd1, 32'd2, 1, 64'd1, 64'd2);
        add_row(REQ_REFL_X, 32'h7fff_ffff, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'd0, 32'd0, 1, 64'h0000_0000_ffff_fffe, 64'd0);
        add_row(REQ_REFL_X, 32'h7fff_ffff, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'd5, 32'd5, 1, 64'd5, 64'd5);
        add_row(REQ_REFL_Y, 32'h8000_0000, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'd0, 32'd0, 1, 64'd0, 64'hffff_ffff_0000_0000);
        add_row(REQ_REFL_X, 32'h8000_0000, $urandom, $urandom);
        add_row(REQ_REFL_Y, 32'hffff_ffff, $urandom, $urandom);
        add_row(REQ_ROT_CW, $urandom, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'h8000_0000, 32'h8000_0000);
        add_row(REQ_ROT_CCW, $urandom, $urandom, $urandom);
        add_row(REQ_ROT_CCW, $urandom, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'h7fff_ffff, 32'h7fff_ffff);
        add_row(REQ_REFL_X, 32'h7fff_ffff, $urandom, $urandom);
        add_row(REQ_POINT, $urandom, 32'hffff_ffff, 32'h8000_0000);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_request(directed[i]);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 300 && n < 450);
            if (n == 550) begin
                s_tvalid <= 1'b0;
                while (pending_points.size() != 0) @(posedge aclk);
            end
            r = '{pick_code(), pick_word(), pick_word(), pick_word(), 1'b0, 64'd0, 64'd0};
            send_request(r);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_points.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
